@@ rtl/pjs_pkg.sv @@
// shared types and constants for the period jitter statistics block
package pjs_pkg;

    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned SUM_W    = 64;
    localparam int unsigned US_W     = 20;
    localparam int unsigned PROD_W   = STAMP_W + US_W;
    localparam int unsigned STEP_W   = 6;
    localparam int unsigned AVG_STEPS  = 32;
    localparam int unsigned CONV_STEPS = PROD_W;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [US_W-1:0]    US_PER_SEC     = US_W'(1000000);
    localparam logic [STAMP_W-1:0] EXPECTED_RESET = STAMP_W'(100000);
    localparam logic [STAMP_W-1:0] CLOCK_HZ_RESET = STAMP_W'(100000000);

    // action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ = 1'b1;

    typedef struct packed {
        logic               action;
        logic [STAMP_W-1:0] timestamp;
    } pjs_in_t;

    typedef struct packed {
        logic [STAMP_W-1:0] min_jitter_us;
        logic [STAMP_W-1:0] max_jitter_us;
        logic [STAMP_W-1:0] avg_jitter_us;
    } pjs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEV,
        ST_UPD,
        ST_AVG,
        ST_MUL,
        ST_CONV,
        ST_DONE
    } pjs_state_t;

endpackage

@@ rtl/period_jitter_statistics_top.sv @@
// top level of the period jitter statistics block: sequencer, shared divider and window state
// A sample transaction (action 0) forms the wrapped period since the previous timestamp and
// its absolute deviation from the expected period register, then folds it into the window
// minimum, maximum, 64-bit sum and saturating count in the DEV and UPD states (the first sample
// after reset only stores its timestamp). A report transaction (action 1) snapshots and clears
// the window; an empty window gives no result. A non-empty report runs one shared restoring
// divider that retires one quotient bit per cycle: first the average division, then for min,
// max and average a multiply followed by a divide for the microsecond conversion. in_stall is
// high while the sequencer is busy. A finished result sits in an output register, so new
// transactions are taken while it waits for the consumer; a second report holds in its last
// cycle until that register empties. Configuration writes are always ready and take effect
// at once.
module period_jitter_statistics_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  pjs_pkg::pjs_in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output pjs_pkg::pjs_out_t                    out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pjs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pjs_pkg::STAMP_W-1:0]          cfg_data
);
    import pjs_pkg::*;

    // conversion operand select
    localparam logic [1:0] CONV_MIN = 2'd0;
    localparam logic [1:0] CONV_MAX = 2'd1;
    localparam logic [1:0] CONV_AVG = 2'd2;

    pjs_state_t state_reg, state_next;

    // configuration
    logic [STAMP_W-1:0] expected_reg, expected_next;
    logic [STAMP_W-1:0] clock_hz_reg, clock_hz_next;

    // window state
    logic [STAMP_W-1:0] prev_stamp_reg, prev_stamp_next;
    logic               primed_reg, primed_next;
    logic [STAMP_W-1:0] win_min_reg, win_min_next;
    logic [STAMP_W-1:0] win_max_reg, win_max_next;
    logic [SUM_W-1:0]   win_sum_reg, win_sum_next;
    logic [STAMP_W-1:0] win_count_reg, win_count_next;

    // sample work value: period, then deviation
    logic [STAMP_W-1:0] work_reg, work_next;

    // report snapshot and conversion results
    logic [STAMP_W-1:0] snap_min_reg, snap_min_next;
    logic [STAMP_W-1:0] snap_max_reg, snap_max_next;
    logic [STAMP_W-1:0] avg_reg, avg_next;
    logic [STAMP_W-1:0] cv_min_reg, cv_min_next;
    logic [STAMP_W-1:0] cv_max_reg, cv_max_next;
    logic [1:0]         conv_sel_reg, conv_sel_next;

    // shared divider
    logic [STAMP_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [STAMP_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    pjs_out_t           out_data_reg, out_data_next;

    logic               in_accept;
    logic               step_last;
    logic [STAMP_W:0]   trial;
    logic [STAMP_W:0]   trial_diff;
    logic               trial_ge;
    logic [SUM_W-1:0]   quo_shift;
    logic [STAMP_W-1:0] rem_step;
    logic [STAMP_W-1:0] mul_op;
    logic [PROD_W-1:0]  product;

    assign in_accept = in_valid && !in_stall;
    assign step_last = (step_reg == '0);

    // one restoring divide step per cycle
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_ge   = (trial >= {1'b0, div_reg});
    assign rem_step   = trial_ge ? trial_diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
    assign quo_shift  = {quo_reg[SUM_W-2:0], trial_ge};

    // cycles to microseconds: product registered into the divider
    always_comb
    begin
        case (conv_sel_reg)
            CONV_MIN: mul_op = snap_min_reg;
            CONV_MAX: mul_op = snap_max_reg;
            default:  mul_op = avg_reg;
        endcase
    end
    assign product = {{US_W{1'b0}}, mul_op} * {{STAMP_W{1'b0}}, US_PER_SEC};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.action == ACT_SAMPLE)
                    begin
                        if (primed_reg)
                            state_next = ST_DEV;
                    end
                    else if (win_count_reg != '0)
                    begin
                        state_next = ST_AVG;
                    end
                end
            end
            ST_DEV:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_IDLE;
            ST_AVG:  if (step_last) state_next = ST_MUL;
            ST_MUL:  state_next = ST_CONV;
            ST_CONV:
            begin
                if (step_last)
                    state_next = (conv_sel_reg == CONV_AVG) ? ST_DONE : ST_MUL;
            end
            ST_DONE: if (!out_valid_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        cfg_ready = 1'b1;
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
    end

    // datapath
    always_comb
    begin
        expected_next   = expected_reg;
        clock_hz_next   = clock_hz_reg;
        prev_stamp_next = prev_stamp_reg;
        primed_next     = primed_reg;
        win_min_next    = win_min_reg;
        win_max_next    = win_max_reg;
        win_sum_next    = win_sum_reg;
        win_count_next  = win_count_reg;
        work_next       = work_reg;
        snap_min_next   = snap_min_reg;
        snap_max_next   = snap_max_reg;
        avg_next        = avg_reg;
        cv_min_next     = cv_min_reg;
        cv_max_next     = cv_max_reg;
        conv_sel_next   = conv_sel_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EXPECTED: expected_next = cfg_data;
                REG_CLOCK_HZ: clock_hz_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.action == ACT_SAMPLE)
                    begin
                        prev_stamp_next = in_data.timestamp;
                        primed_next     = 1'b1;
                        work_next       = in_data.timestamp - prev_stamp_reg;
                    end
                    else
                    begin
                        // snapshot, clear window, load average division
                        snap_min_next  = win_min_reg;
                        snap_max_next  = win_max_reg;
                        rem_next       = win_sum_reg[SUM_W-1:STAMP_W];
                        quo_next       = {win_sum_reg[STAMP_W-1:0], {STAMP_W{1'b0}}};
                        div_next       = win_count_reg;
                        step_next      = STEP_W'(AVG_STEPS - 1);
                        win_min_next   = '1;
                        win_max_next   = '0;
                        win_sum_next   = '0;
                        win_count_next = '0;
                    end
                end
            end
            ST_DEV:
            begin
                work_next = (work_reg >= expected_reg) ? work_reg - expected_reg
                                                       : expected_reg - work_reg;
            end
            ST_UPD:
            begin
                if (work_reg < win_min_reg)
                    win_min_next = work_reg;
                if (work_reg > win_max_reg)
                    win_max_next = work_reg;
                // count saturates, sum freezes with it
                if (win_count_reg != '1)
                begin
                    win_sum_next   = win_sum_reg + {{(SUM_W-STAMP_W){1'b0}}, work_reg};
                    win_count_next = win_count_reg + 1'b1;
                end
            end
            ST_AVG:
            begin
                rem_next  = rem_step;
                quo_next  = quo_shift;
                step_next = step_reg - 1'b1;
                if (step_last)
                begin
                    avg_next      = quo_shift[STAMP_W-1:0];
                    conv_sel_next = CONV_MIN;
                end
            end
            ST_MUL:
            begin
                rem_next  = '0;
                quo_next  = {product, {(SUM_W-PROD_W){1'b0}}};
                // zero clock rate treated as one
                div_next  = (clock_hz_reg == '0) ? STAMP_W'(1) : clock_hz_reg;
                step_next = STEP_W'(CONV_STEPS - 1);
            end
            ST_CONV:
            begin
                rem_next  = rem_step;
                quo_next  = quo_shift;
                step_next = step_reg - 1'b1;
                if (step_last)
                begin
                    case (conv_sel_reg)
                        CONV_MIN: cv_min_next = quo_shift[STAMP_W-1:0];
                        CONV_MAX: cv_max_next = quo_shift[STAMP_W-1:0];
                        default: ;
                    endcase
                    conv_sel_next = conv_sel_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.min_jitter_us = cv_min_reg;
                    out_data_next.max_jitter_us = cv_max_reg;
                    out_data_next.avg_jitter_us = quo_reg[STAMP_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            expected_reg   <= EXPECTED_RESET;
            clock_hz_reg   <= CLOCK_HZ_RESET;
            prev_stamp_reg <= '0;
            primed_reg     <= 1'b0;
            win_min_reg    <= '1;
            win_max_reg    <= '0;
            win_sum_reg    <= '0;
            win_count_reg  <= '0;
            conv_sel_reg   <= CONV_MIN;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            expected_reg   <= expected_next;
            clock_hz_reg   <= clock_hz_next;
            prev_stamp_reg <= prev_stamp_next;
            primed_reg     <= primed_next;
            win_min_reg    <= win_min_next;
            win_max_reg    <= win_max_next;
            win_sum_reg    <= win_sum_next;
            win_count_reg  <= win_count_next;
            conv_sel_reg   <= conv_sel_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        snap_min_reg <= snap_min_next;
        snap_max_reg <= snap_max_next;
        avg_reg      <= avg_next;
        cv_min_reg   <= cv_min_next;
        cv_max_reg   <= cv_max_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_reg      <= div_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // divider never runs with a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AVG || state_reg == ST_CONV) |-> (div_reg != '0))
        else $error("divider running with zero divisor");

    // partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AVG || state_reg == ST_CONV) |-> (rem_reg < div_reg))
        else $error("divider remainder out of range");

    // an empty window holds its cleared values
    assert property (@(posedge clk) disable iff (!rst_n)
        (win_count_reg == '0) |-> (win_sum_reg == '0 && win_max_reg == '0 && win_min_reg == '1))
        else $error("empty window not clean");

    // a finished report reaches the output register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_valid_reg) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("report result not delivered");
`endif

endmodule

@@ verif/tb_period_jitter_statistics_top.sv @@
// self-checking testbench for the period jitter statistics block
module tb_period_jitter_statistics_top;
    import pjs_pkg::*;

    localparam int unsigned RESET_CYCLES    = 8;
    // a non-empty report fits in this wait with margin
    localparam int unsigned SETTLE_CYCLES   = 250;
    // receiver hold-off, long enough for a second report to hold behind a waiting one
    localparam int unsigned HOLD_CYCLES     = 2000;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 232;
    // slowest legal run is well under this: every item a report, every wait at its longest
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    typedef enum logic {ROW_TXN, ROW_CFG} row_kind_t;

    // one line of the directed table: either a transaction or a register setting
    typedef struct {
        row_kind_t   kind;
        pjs_in_t     txn;
        bit          typed;
        pjs_out_t    golden;
        logic [31:0] period_val;
        logic [31:0] hz_val;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    pjs_in_t           in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    pjs_out_t          out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_EXPECTED;
    logic [STAMP_W-1:0]   cfg_data = '0;

    // jitter window shadow state, starts at its reset values
    logic [31:0] nominal_period = EXPECTED_RESET;
    logic [31:0] counter_hz     = CLOCK_HZ_RESET;
    logic [31:0] last_stamp     = '0;
    bit          stamp_seen     = 1'b0;
    logic [31:0] dev_min        = '1;
    logic [31:0] dev_max        = '0;
    logic [63:0] dev_sum        = '0;
    logic [31:0] dev_count      = '0;

    pjs_out_t    expected_reports[$];
    stim_row_t   directed_rows[$];

    // idling knobs shared by the sender and the receiver
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    bit          hold_pending    = 1'b0;
    int unsigned hold_left       = 0;

    int unsigned     failures    = 0;
    longint unsigned cycle_count = 0;
    logic [31:0]     stamp_cursor = '0;

    period_jitter_statistics_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // floor(cycles * 1e6 / hz), keeping the low 32 bits; zero hz counts as 1
    function automatic logic [31:0] scale_to_micro(input logic [31:0] cycles);
        logic [63:0] divisor;
        logic [63:0] quot;
        divisor = (counter_hz == '0) ? 64'd1 : 64'(counter_hz);
        quot = (64'(cycles) * 64'(US_PER_SEC)) / divisor;
        return quot[31:0];
    endfunction

    // advance the shadow window by one transaction; returns 1 when a report comes out
    function automatic bit fold_transaction(input pjs_in_t txn, output pjs_out_t rep);
        logic [31:0] period;
        logic [31:0] dev;
        logic [31:0] avg;
        rep = '0;
        if (txn.action == ACT_SAMPLE)
        begin
            // first sample after reset only primes the previous timestamp
            if (!stamp_seen)
            begin
                last_stamp = txn.timestamp;
                stamp_seen = 1'b1;
                return 1'b0;
            end
            period = txn.timestamp - last_stamp;
            last_stamp = txn.timestamp;
            dev = (period >= nominal_period) ? period - nominal_period
                                             : nominal_period - period;
            if (dev < dev_min)
                dev_min = dev;
            if (dev > dev_max)
                dev_max = dev;
            // count saturates; sum freezes with it
            if (dev_count != '1)
            begin
                dev_sum = dev_sum + 64'(dev);
                dev_count = dev_count + 1'b1;
            end
            return 1'b0;
        end
        // report: snapshot, then clear; an empty window reports nothing
        if (dev_count != '0)
        begin
            avg = 32'(dev_sum / 64'(dev_count));
            rep.min_jitter_us = scale_to_micro(dev_min);
            rep.max_jitter_us = scale_to_micro(dev_max);
            rep.avg_jitter_us = scale_to_micro(avg);
        end
        fold_transaction = (dev_count != '0);
        dev_min   = '1;
        dev_max   = '0;
        dev_sum   = '0;
        dev_count = '0;
    endfunction

    function automatic void add_txn(input logic act, input logic [31:0] stamp,
                                    input bit typed = 1'b0, input logic [31:0] mn = '0,
                                    input logic [31:0] mx = '0, input logic [31:0] avg = '0);
        stim_row_t row;
        row = '{kind: ROW_TXN, default: '0};
        row.kind = ROW_TXN;
        row.txn.action = act;
        row.txn.timestamp = stamp;
        row.typed = typed;
        row.golden.min_jitter_us = mn;
        row.golden.max_jitter_us = mx;
        row.golden.avg_jitter_us = avg;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [31:0] period, input logic [31:0] hz);
        stim_row_t row;
        row = '{kind: ROW_CFG, default: '0};
        row.kind = ROW_CFG;
        row.period_val = period;
        row.hz_val = hz;
        directed_rows.push_back(row);
    endfunction

    // offer one transaction, hold it until taken, then log what it should produce
    task automatic send_txn(input pjs_in_t txn, input bit typed = 1'b0,
                            input pjs_out_t typed_rep = '0);
        pjs_out_t rep;
        bit       has_rep;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= txn;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        has_rep = fold_transaction(txn, rep);
        if (typed)
            expected_reports.push_back(typed_rep);
        else if (has_rep)
            expected_reports.push_back(rep);
    endtask

    // stop offering, let every pending report drain, then let a trailing sample finish
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers back to back, valid held across the pair
    task automatic program_registers(input logic [31:0] period, input logic [31:0] hz);
        cfg_valid <= 1'b1;
        cfg_index <= REG_EXPECTED;
        cfg_data  <= period;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        nominal_period = period;
        cfg_index <= REG_CLOCK_HZ;
        cfg_data  <= hz;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        counter_hz = hz;
        cfg_valid <= 1'b0;
    endtask

    // receiver: check each report transaction, then pick the next stall value
    always @(posedge clk)
    begin
        pjs_out_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected report min %0d max %0d avg %0d", $time,
                         out_data.min_jitter_us, out_data.max_jitter_us,
                         out_data.avg_jitter_us);
                failures++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (out_data.min_jitter_us !== want.min_jitter_us)
                begin
                    $display("%0t: min_jitter_us expected %0d actual %0d", $time,
                             want.min_jitter_us, out_data.min_jitter_us);
                    failures++;
                end
                if (out_data.max_jitter_us !== want.max_jitter_us)
                begin
                    $display("%0t: max_jitter_us expected %0d actual %0d", $time,
                             want.max_jitter_us, out_data.max_jitter_us);
                    failures++;
                end
                if (out_data.avg_jitter_us !== want.avg_jitter_us)
                begin
                    $display("%0t: avg_jitter_us expected %0d actual %0d", $time,
                             want.avg_jitter_us, out_data.avg_jitter_us);
                    failures++;
                end
            end
        end
        // long hold-off requested by the stimulus, counted here
        if (hold_pending)
        begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d reports still pending", $time,
                     expected_reports.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        pjs_in_t     txn;
        logic [31:0] period_pick;
        logic [31:0] hz_pick;
        int          jitter;
        int unsigned pick;

        // directed table; typed results use the clock rate register in force at that row (100 MHz after reset)
        add_txn(ACT_REPORT, 32'h0);             // empty after reset, nothing comes out
        add_txn(ACT_SAMPLE, 32'd0);             // first sample only primes
        add_txn(ACT_REPORT, 32'h0);             // still empty, priming kept
        add_txn(ACT_SAMPLE, 32'd100000);        // exactly nominal, zero deviation
        add_txn(ACT_REPORT, 32'h0, 1'b1, 32'd0, 32'd0, 32'd0);
        add_txn(ACT_SAMPLE, 32'd200100);        // period 100100, late against nominal
        add_txn(ACT_SAMPLE, 32'd299900);        // period 99800, early against nominal
        add_txn(ACT_REPORT, '1, 1'b1, 32'd1, 32'd2, 32'd1);  // timestamp ignored
        add_txn(ACT_SAMPLE, '1);                // huge period
        add_txn(ACT_SAMPLE, 32'd99999);         // counter wraps, period back to nominal
        add_txn(ACT_REPORT, 32'h0);
        // zero nominal period, 1 Hz clock: conversion overflows 32 bits
        add_cfg('0, 32'd1);
        add_txn(ACT_SAMPLE, 32'h8000_0000);
        add_txn(ACT_SAMPLE, 32'h8000_0001);
        add_txn(ACT_REPORT, 32'h0);
        // both registers at full scale
        add_cfg('1, '1);
        add_txn(ACT_SAMPLE, 32'h8000_0001);     // zero period, deviation all ones
        add_txn(ACT_SAMPLE, 32'h0);
        add_txn(ACT_REPORT, '1);
        // zero clock counts as 1 Hz: one cycle reads as a million us
        add_cfg(EXPECTED_RESET, '0);
        add_txn(ACT_SAMPLE, 32'd100001);
        add_txn(ACT_REPORT, 32'h0, 1'b1, 32'd1000000, 32'd1000000, 32'd1000000);
        add_txn(ACT_REPORT, 32'h0);             // cleared window stays empty
        add_cfg(EXPECTED_RESET, CLOCK_HZ_RESET);
        add_txn(ACT_SAMPLE, 32'h5555_5555);
        add_txn(ACT_SAMPLE, 32'hAAAA_AAAA);
        add_txn(ACT_REPORT, 32'h0);
        // the saturated count needs 2^32 - 1 samples in one window, out of reach here

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle();
                program_registers(directed_rows[i].period_val, directed_rows[i].hz_val);
            end
            else
                send_txn(directed_rows[i].txn, directed_rows[i].typed,
                         directed_rows[i].golden);
        end
        stamp_cursor = last_stamp;

        for (int p = 0; p < PHASES; p++)
        begin
            // block is idle here: new register setting for this phase
            settle();
            case ($urandom_range(5))
                0: period_pick = EXPECTED_RESET;
                1: period_pick = '0;
                2: period_pick = '1;
                3: period_pick = $urandom_range(2000000, 1000);
                4: period_pick = $urandom();
                default: period_pick = $urandom_range(100, 1);
            endcase
            case ($urandom_range(5))
                0: hz_pick = CLOCK_HZ_RESET;
                1: hz_pick = 32'd1;
                2: hz_pick = '1;
                3: hz_pick = $urandom_range(400000000, 1000000);
                4: hz_pick = $urandom();
                default: hz_pick = 32'd1000000;
            endcase
            program_registers(period_pick, hz_pick);

            // idling pattern rotates: none, sender, receiver, both
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            // receiver goes quiet while the sender keeps offering back to back
            if (p == 4)
                hold_pending = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                txn.timestamp = $urandom();
                pick = $urandom_range(99);
                if (pick < 12)
                    txn.action = ACT_REPORT;
                else
                begin
                    txn.action = ACT_SAMPLE;
                    // mostly periodic wakeups near nominal, the rest arbitrary stamps
                    if (pick < 90)
                    begin
                        case ($urandom_range(3))
                            0: jitter = 0;
                            1: jitter = int'($urandom_range(32)) - 16;
                            2: jitter = int'($urandom_range(10000)) - 5000;
                            default: jitter = int'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
                        endcase
                        txn.timestamp = stamp_cursor + nominal_period + 32'(jitter);
                    end
                    stamp_cursor = txn.timestamp;
                end
                send_txn(txn);
            end
        end

        sender_idle_pct = 0;
        recv_stall_pct = 0;
        settle();
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
